// ----- rtl/sha1_hash_engine_macros.svh -----
// assertion macros shared by the sha-1 engine rtl
// expects clk and rst_n in the scope of every use
`ifndef SHA1_HASH_ENGINE_MACROS_SVH
`define SHA1_HASH_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SHA1_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha1 assertion failed");

// next-cycle implication
`define SHA1_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha1 assertion failed");

`else

`define SHA1_ASSERT_IMP(label, ante, cons)
`define SHA1_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/sha1_pkg.sv -----
// shared types, constants and functions of the sha-1 engine
// no dependencies
`timescale 1ns / 1ps

package sha1_pkg;

    localparam int ROUND_W    = 7;
    localparam int FILL_W     = 6;
    localparam int COUNT_W    = 61;
    localparam int WIDX_W     = 3;
    localparam int BLK_WORDS  = 16;
    localparam int CHAIN_WORDS = 5;

    localparam logic [ROUND_W-1:0] LAST_ROUND    = 7'd79;
    localparam logic [ROUND_W-1:0] SCHED_ROUNDS  = 7'd16;
    localparam logic [WIDX_W-1:0]  LAST_WORD_IDX = 3'd4;
    localparam logic [7:0]         PAD_BYTE      = 8'h80;
    localparam logic [3:0]         LEN_HI_SLOT   = 4'd14;
    localparam logic [3:0]         LEN_LO_SLOT   = 4'd15;

    // controller to datapath commands
    typedef struct packed {
        logic                take_byte;
        logic                shift_pad;
        logic                shift_zero;
        logic                shift_len_hi;
        logic                shift_len_lo;
        logic                cmp_load;
        logic                cmp_round;
        logic                cmp_add;
        logic                clear_count;
        logic                out_load;
        logic [ROUND_W-1:0]  round;
        logic [WIDX_W-1:0]   out_idx;
    } sha1_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [3:0] fill_word;
        logic       fill_last;
    } sha1_stat_t;

    function automatic logic [31:0] sha1_iv(input logic [WIDX_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            3'd4:    v = 32'hC3D2E1F0;
            default: v = 32'h67452301;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sha1_k(input logic [ROUND_W-1:0] t);
        logic [31:0] k;
        if (t < 7'd20)
            k = 32'h5A827999;
        else if (t < 7'd40)
            k = 32'h6ED9EBA1;
        else if (t < 7'd60)
            k = 32'h8F1BBCDC;
        else
            k = 32'hCA62C1D6;
        return k;
    endfunction

endpackage

// ----- rtl/sha1_hash_engine.sv -----
// sha-1 hash engine top level: stream ports, controller and datapath
// depends on sha1_pkg, sha1_ctrl, sha1_datapath
`timescale 1ns / 1ps

// usage
// - input stream: one beat per message byte; s_tuser[0] says whether s_tdata holds a
//   byte, s_tlast marks the final beat of a message (a beat with no byte and tlast
//   hashes the message as it stands, so an empty message is one such beat)
// - output stream: five beats per message, digest word 0 (most significant) first;
//   m_tuser carries the word index, m_tlast is set on word 4
// - timing: byte beats are taken one per cycle while the engine is idle; the beat that
//   completes a 64-byte block starts a busy stretch (load, 80 rounds at one round per
//   cycle, chaining add) in which no input is taken
// - end of message: a pad step, one step per zero or length word up to the block
//   end, then the final compression; when the length does not fit in the current
//   block, an extra step and a second compression come in between; after the final
//   chaining add the controller enters its drain state, then loads word 0 for output
// - s_tready is low from the end beat until the fifth digest word has been
//   loaded into the output register
// - a stalled receiver holds the digest words one at a time; the engine waits in
//   its drain state and takes no new input until all five words are loaded
// - reset clears the controller, restores the initial chaining values and zeroes
//   the byte counters; no clearing pass is needed

module sha1_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);
    import sha1_pkg::*;

    sha1_cmd_t  cmd;
    sha1_stat_t stat;

    // sequencing: intake, padding steps, round counter, digest drain
    sha1_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_present (s_tuser[0]),
        .in_end     (s_tlast),
        .in_ready   (s_tready),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .cmd        (cmd),
        .stat       (stat)
    );

    // storage and arithmetic: block window, rounds, chaining words, output register
    sha1_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .out_word (m_tdata),
        .out_idx  (m_tuser),
        .out_last (m_tlast)
    );

endmodule

// ----- rtl/sha1_datapath.sv -----
// sha-1 datapath: block shift line, round registers, chaining words, counters
// depends on sha1_pkg
`timescale 1ns / 1ps

module sha1_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            byte_in,
    input  sha1_pkg::sha1_cmd_t   cmd,
    output sha1_pkg::sha1_stat_t  stat,
    output logic [31:0]           out_word,
    output logic [2:0]            out_idx,
    output logic                  out_last
);
    import sha1_pkg::*;

    logic [31:0]        blk_reg [BLK_WORDS];
    logic [31:0]        rnd_reg [CHAIN_WORDS];
    logic [31:0]        chain_reg [CHAIN_WORDS];
    logic [23:0]        acc_reg, acc_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [31:0]        out_word_reg;
    logic [WIDX_W-1:0]  out_idx_reg;
    logic               out_last_reg;

    logic               word_shift;
    logic [31:0]        word_in;
    logic [31:0]        sched_mix, sched_w;
    logic [31:0]        f_val, round_sum;
    logic [3:0]         word_after;

    // message schedule from the sliding window of 16 words
    assign sched_mix = blk_reg[13] ^ blk_reg[8] ^ blk_reg[2] ^ blk_reg[0];
    assign sched_w   = (cmd.round < SCHED_ROUNDS) ? blk_reg[0]
                                                   : {sched_mix[30:0], sched_mix[31]};

    always_comb
    begin
        if (cmd.round < 7'd20)
            f_val = (rnd_reg[1] & rnd_reg[2]) | (~rnd_reg[1] & rnd_reg[3]);
        else if (cmd.round < 7'd40)
            f_val = rnd_reg[1] ^ rnd_reg[2] ^ rnd_reg[3];
        else if (cmd.round < 7'd60)
            f_val = (rnd_reg[1] & rnd_reg[2]) | (rnd_reg[1] & rnd_reg[3])
                  | (rnd_reg[2] & rnd_reg[3]);
        else
            f_val = rnd_reg[1] ^ rnd_reg[2] ^ rnd_reg[3];
    end

    assign round_sum = {rnd_reg[0][26:0], rnd_reg[0][31:27]} + f_val + rnd_reg[4]
                     + sha1_k(cmd.round) + sched_w;

    assign word_after = fill_reg[5:2] + 4'd1;

    always_comb
    begin
        word_shift = 1'b0;
        word_in    = '0;
        acc_next   = acc_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        if (cmd.take_byte)
        begin
            acc_next   = {acc_reg[15:0], byte_in};
            fill_next  = fill_reg + 6'd1;
            count_next = count_reg + 61'd1;
            if (fill_reg[1:0] == 2'd3)
            begin
                word_shift = 1'b1;
                word_in    = {acc_reg, byte_in};
            end
        end
        if (cmd.shift_pad)
        begin
            // close the partial word with the pad byte
            word_shift = 1'b1;
            fill_next  = {word_after, 2'b00};
            case (fill_reg[1:0])
                2'd0:    word_in = {PAD_BYTE, 24'h0};
                2'd1:    word_in = {acc_reg[7:0], PAD_BYTE, 16'h0};
                2'd2:    word_in = {acc_reg[15:0], PAD_BYTE, 8'h0};
                default: word_in = {acc_reg[23:0], PAD_BYTE};
            endcase
        end
        if (cmd.shift_zero)
        begin
            word_shift = 1'b1;
            word_in    = '0;
            fill_next  = {word_after, 2'b00};
        end
        if (cmd.shift_len_hi)
        begin
            word_shift = 1'b1;
            word_in    = count_reg[60:29];
            fill_next  = {word_after, 2'b00};
        end
        if (cmd.shift_len_lo)
        begin
            word_shift = 1'b1;
            word_in    = {count_reg[28:0], 3'b000};
            fill_next  = {word_after, 2'b00};
        end
        if (cmd.cmp_round)
        begin
            word_shift = 1'b1;
            word_in    = sched_w;
        end
        if (cmd.clear_count)
            count_next = '0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
            for (int i = 0; i < CHAIN_WORDS; i++)
                chain_reg[i] <= sha1_iv(WIDX_W'(i));
        end
        else
        begin
            fill_reg  <= fill_next;
            count_reg <= count_next;
            if (cmd.cmp_add)
            begin
                for (int i = 0; i < CHAIN_WORDS; i++)
                    chain_reg[i] <= chain_reg[i] + rnd_reg[i];
            end
            else if (cmd.out_load)
            begin
                // drain toward word 0, refill with initial values behind
                for (int i = 0; i < CHAIN_WORDS - 1; i++)
                    chain_reg[i] <= chain_reg[i + 1];
                chain_reg[CHAIN_WORDS-1] <= sha1_iv(cmd.out_idx);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (word_shift)
        begin
            for (int i = 0; i < BLK_WORDS - 1; i++)
                blk_reg[i] <= blk_reg[i + 1];
            blk_reg[BLK_WORDS-1] <= word_in;
        end
        if (cmd.cmp_load)
        begin
            for (int i = 0; i < CHAIN_WORDS; i++)
                rnd_reg[i] <= chain_reg[i];
        end
        else if (cmd.cmp_round)
        begin
            rnd_reg[4] <= rnd_reg[3];
            rnd_reg[3] <= rnd_reg[2];
            rnd_reg[2] <= {rnd_reg[1][1:0], rnd_reg[1][31:2]};
            rnd_reg[1] <= rnd_reg[0];
            rnd_reg[0] <= round_sum;
        end
        if (cmd.out_load)
        begin
            out_word_reg <= chain_reg[0];
            out_idx_reg  <= cmd.out_idx;
            out_last_reg <= (cmd.out_idx == LAST_WORD_IDX);
        end
    end

    assign stat.fill_word = fill_reg[5:2];
    assign stat.fill_last = (fill_reg == 6'd63);
    assign out_word = out_word_reg;
    assign out_idx  = out_idx_reg;
    assign out_last = out_last_reg;

endmodule

// ----- rtl/sha1_ctrl.sv -----
// sha-1 controller: sequences byte intake, padding, 80 rounds and digest drain
// depends on sha1_pkg and sha1_hash_engine_macros.svh
`timescale 1ns / 1ps
`include "sha1_hash_engine_macros.svh"

module sha1_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_present,
    input  logic                  in_end,
    output logic                  in_ready,
    input  logic                  out_ready,
    output logic                  out_valid,
    output sha1_pkg::sha1_cmd_t   cmd,
    input  sha1_pkg::sha1_stat_t  stat
);
    import sha1_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_PAD_FIRST = 4'd1;
    localparam logic [3:0] ST_ZERO_A    = 4'd2;
    localparam logic [3:0] ST_ZERO_B    = 4'd3;
    localparam logic [3:0] ST_LEN_LO    = 4'd4;
    localparam logic [3:0] ST_CMP_LOAD  = 4'd5;
    localparam logic [3:0] ST_CMP_ROUND = 4'd6;
    localparam logic [3:0] ST_CMP_ADD   = 4'd7;
    localparam logic [3:0] ST_OUT       = 4'd8;

    // where to go after a compression
    localparam logic [1:0] RET_BLOCK = 2'd0;
    localparam logic [1:0] RET_EXTRA = 2'd1;
    localparam logic [1:0] RET_FINAL = 2'd2;

    logic [3:0]         state_reg, state_next;
    logic [1:0]         ret_reg, ret_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [WIDX_W-1:0]  out_idx_reg, out_idx_next;
    logic               eom_reg, eom_next;
    logic               m_valid_reg, m_valid_next;
    logic               accept, out_load;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || out_ready);
    assign m_valid_next = out_load || (m_valid_reg && !out_ready);

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        round_next   = round_reg;
        out_idx_next = out_idx_reg;
        eom_next     = eom_reg;
        cmd              = '0;
        cmd.round        = round_reg;
        cmd.out_idx      = out_idx_reg;
        cmd.out_load     = out_load;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    eom_next      = in_end;
                    cmd.take_byte = in_present;
                    if (in_present && stat.fill_last)
                    begin
                        ret_next   = RET_BLOCK;
                        state_next = ST_CMP_LOAD;
                    end
                    else if (in_end)
                        state_next = ST_PAD_FIRST;
                end
            end
            ST_PAD_FIRST:
            begin
                cmd.shift_pad = 1'b1;
                // no room left for the length words in this block
                if (stat.fill_word >= LEN_HI_SLOT)
                    state_next = ST_ZERO_A;
                else
                    state_next = ST_ZERO_B;
            end
            ST_ZERO_A:
            begin
                if (stat.fill_word == 4'd0)
                begin
                    ret_next   = RET_EXTRA;
                    state_next = ST_CMP_LOAD;
                end
                else
                    cmd.shift_zero = 1'b1;
            end
            ST_ZERO_B:
            begin
                if (stat.fill_word == LEN_HI_SLOT)
                begin
                    cmd.shift_len_hi = 1'b1;
                    state_next       = ST_LEN_LO;
                end
                else
                    cmd.shift_zero = 1'b1;
            end
            ST_LEN_LO:
            begin
                cmd.shift_len_lo = 1'b1;
                ret_next         = RET_FINAL;
                state_next       = ST_CMP_LOAD;
            end
            ST_CMP_LOAD:
            begin
                cmd.cmp_load    = 1'b1;
                cmd.clear_count = (ret_reg == RET_FINAL);
                round_next      = '0;
                state_next      = ST_CMP_ROUND;
            end
            ST_CMP_ROUND:
            begin
                cmd.cmp_round = 1'b1;
                if (round_reg == LAST_ROUND)
                    state_next = ST_CMP_ADD;
                else
                    round_next = round_reg + 7'd1;
            end
            ST_CMP_ADD:
            begin
                cmd.cmp_add = 1'b1;
                unique case (ret_reg)
                    RET_BLOCK: state_next = eom_reg ? ST_PAD_FIRST : ST_IDLE;
                    RET_EXTRA: state_next = ST_ZERO_B;
                    RET_FINAL:
                    begin
                        out_idx_next = '0;
                        state_next   = ST_OUT;
                    end
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == LAST_WORD_IDX)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ret_reg     <= RET_BLOCK;
            round_reg   <= '0;
            out_idx_reg <= '0;
            eom_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            round_reg   <= round_next;
            out_idx_reg <= out_idx_next;
            eom_reg     <= eom_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign out_valid = m_valid_reg;

    `SHA1_ASSERT_IMP(a_round_range, state_reg == ST_CMP_ROUND, round_reg <= LAST_ROUND)
    `SHA1_ASSERT_IMP(a_len_lo_slot, state_reg == ST_LEN_LO, stat.fill_word == LEN_LO_SLOT)
    `SHA1_ASSERT_IMP(a_out_idx, out_load, out_idx_reg <= LAST_WORD_IDX)
    `SHA1_ASSERT_NEXT(a_final_out, state_reg == ST_CMP_ADD && ret_reg == RET_FINAL, state_reg == ST_OUT)
    `SHA1_ASSERT_NEXT(a_end_busy, accept && in_end, !in_ready)

endmodule
